// ===== hdl/postfix_expression_evaluator_assert.svh =====
// assertion macros for the postfix expression evaluator checker
// depends on nothing; expects clk and arst_n in the including scope
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// same-cycle implication
`define PEE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pee check failed");

// next-cycle implication
`define PEE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pee check failed");

`endif

// ===== hdl/pee_pkg.sv =====
// shared types, constants and codes of the postfix expression evaluator
// depends on nothing
package pee_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int OUT_W       = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int AW          = $clog2(STACK_DEPTH);
	localparam int DC_W        = $clog2(VALUE_WIDTH);
	localparam int CQ_DEPTH    = 4;
	localparam int CQ_AW       = $clog2(CQ_DEPTH);

	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_TOKEN = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_DIV_ZERO  = 3'd3,
		ST_DEPTH     = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		TK_DIGIT,
		TK_OP,
		TK_BAD
	} tok_kind_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_EXEC,
		BK_DIV,
		BK_DIVEND,
		BK_FIN
	} bk_state_t;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] value;
		logic [2:0]              status;
	} out_item_t;

	// one classified token, possibly closing the expression
	typedef struct packed {
		logic       has_tok;
		tok_kind_t  kind;
		logic [7:0] ch;
		logic       last;
	} cmd_t;

	// queue side of the handshake between the two halves
	typedef struct packed {
		logic empty;
		logic full;
	} cq_flags_t;

endpackage

// ===== hdl/pee_cmd_fifo.sv =====
// short command queue between tokenizer and stack engine
// depends on pee_pkg
module pee_cmd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  pee_pkg::cmd_t    wdata,
	input  logic             rd,
	output pee_pkg::cmd_t    rdata,
	output pee_pkg::cq_flags_t flags
);

	pee_pkg::cmd_t                  mem_q [pee_pkg::CQ_DEPTH];
	logic [pee_pkg::CQ_AW-1:0]      wp_q;
	logic [pee_pkg::CQ_AW-1:0]      rp_q;
	logic [pee_pkg::CQ_AW:0]        cnt_q;
	logic                           do_wr;
	logic                           do_rd;

	assign flags.empty = (cnt_q == '0);
	assign flags.full  = (cnt_q == (pee_pkg::CQ_AW+1)'(pee_pkg::CQ_DEPTH));
	assign do_wr = wr && !flags.full;
	assign do_rd = rd && !flags.empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/pee_front.sv =====
// tokenizer: collects one-character tokens and classifies them into commands
// depends on pee_pkg
module pee_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  pee_pkg::in_item_t  item,
	input  pee_pkg::cq_flags_t flags,
	output logic               cq_wr,
	output pee_pkg::cmd_t      cq_data
);

	logic [7:0] pc_q;
	logic       pv_q;
	logic       tl_q;
	logic [7:0] n_pc;
	logic       n_pv;
	logic       n_tl;
	logic [7:0] t_pc;
	logic       t_pv;
	logic       t_tl;
	logic       is_sp;
	logic       acc;

	function automatic pee_pkg::tok_kind_t classify(input logic [7:0] c, input logic longer);
		pee_pkg::tok_kind_t k;
		if (longer) begin
			k = pee_pkg::TK_BAD;
		end else if (c >= pee_pkg::CH_ZERO && c <= pee_pkg::CH_NINE) begin
			k = pee_pkg::TK_DIGIT;
		end else if (c == pee_pkg::CH_PLUS || c == pee_pkg::CH_MINUS ||
			c == pee_pkg::CH_STAR || c == pee_pkg::CH_SLASH) begin
			k = pee_pkg::TK_OP;
		end else begin
			k = pee_pkg::TK_BAD;
		end
		return k;
	endfunction

	assign full  = flags.full;
	assign acc   = push && !flags.full;
	assign is_sp = (item.byte_in == pee_pkg::CH_SPACE) ||
		(item.byte_in >= pee_pkg::CH_TAB && item.byte_in <= pee_pkg::CH_CR);

	always_comb begin
		// token state after this byte, before the end mark
		t_pc = pc_q;
		t_pv = pv_q;
		t_tl = tl_q;
		cq_data = '0;
		if (is_sp) begin
			cq_data.has_tok = pv_q;
			cq_data.kind    = classify(pc_q, tl_q);
			cq_data.ch      = pc_q;
			t_pc = '0;
			t_pv = 1'b0;
			t_tl = 1'b0;
		end else if (pv_q) begin
			t_tl = 1'b1;
		end else begin
			t_pc = item.byte_in;
			t_pv = 1'b1;
		end
		n_pc = t_pc;
		n_pv = t_pv;
		n_tl = t_tl;
		if (item.last_byte) begin
			cq_data.last = 1'b1;
			if (!is_sp) begin
				cq_data.has_tok = t_pv;
				cq_data.kind    = classify(t_pc, t_tl);
				cq_data.ch      = t_pc;
			end
			n_pc = '0;
			n_pv = 1'b0;
			n_tl = 1'b0;
		end
		cq_wr = acc && (cq_data.has_tok || cq_data.last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			pv_q <= 1'b0;
			tl_q <= 1'b0;
		end else if (acc) begin
			pc_q <= n_pc;
			pv_q <= n_pv;
			tl_q <= n_tl;
		end
	end

endmodule

// ===== hdl/pee_back.sv =====
// stack engine: runs commands on the value stack, bit-serial divider, result register
// depends on pee_pkg
module pee_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pee_pkg::cq_flags_t  flags,
	input  pee_pkg::cmd_t       cq_data,
	output logic                cq_rd,
	output logic                empty,
	input  logic                pop,
	output pee_pkg::out_item_t  result
);

	localparam int W = pee_pkg::VALUE_WIDTH;

	pee_pkg::bk_state_t            state_q;
	pee_pkg::bk_state_t            state_d;
	logic [W-1:0]                  stack_q [pee_pkg::STACK_DEPTH];
	logic [W-1:0]                  rdata_q;
	logic [W-1:0]                  tos_q;
	logic [pee_pkg::CNT_W-1:0]     cnt_q;
	pee_pkg::status_t              status_q;
	pee_pkg::cmd_t                 cmd_q;
	logic [W-1:0]                  rem_q;
	logic [W-1:0]                  quo_q;
	logic [W-1:0]                  dvs_q;
	logic                          neg_q;
	logic [pee_pkg::DC_W-1:0]      dc_q;
	logic                          out_valid_q;
	pee_pkg::out_item_t            out_q;

	logic                          take;
	logic                          live;
	logic                          is_full;
	logic                          do_push;
	logic                          op_ok;
	logic                          out_free;
	logic [pee_pkg::AW-1:0]        top_idx;
	logic [pee_pkg::AW-1:0]        rd_idx;
	logic [pee_pkg::CNT_W-1:0]     cnt_m1;
	logic [pee_pkg::CNT_W-1:0]     cnt_m2;
	logic [W-1:0]                  digit;
	logic [W-1:0]                  alu_res;
	logic [W:0]                    trial;
	logic [W:0]                    diff;
	logic [W-1:0]                  mag_l;
	logic [W-1:0]                  mag_r;

	assign empty  = !out_valid_q;
	assign result = out_q;

	assign cnt_m1  = cnt_q - 1'b1;
	assign cnt_m2  = cnt_q - 2'd2;
	assign top_idx = cnt_m1[pee_pkg::AW-1:0];
	assign rd_idx  = cnt_m2[pee_pkg::AW-1:0];
	assign is_full = (cnt_q == pee_pkg::CNT_W'(pee_pkg::STACK_DEPTH));
	assign digit   = W'(cq_data.ch - pee_pkg::CH_ZERO);
	assign out_free = !out_valid_q || pop;

	assign mag_l = rdata_q[W-1] ? (W'(0) - rdata_q) : rdata_q;
	assign mag_r = tos_q[W-1] ? (W'(0) - tos_q) : tos_q;
	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_comb begin
		unique case (cmd_q.ch)
			pee_pkg::CH_PLUS:  alu_res = rdata_q + tos_q;
			pee_pkg::CH_MINUS: alu_res = rdata_q - tos_q;
			default:           alu_res = W'(rdata_q * tos_q);
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pee_pkg::BK_IDLE: begin
				if (!flags.empty) begin
					if (cq_data.has_tok && status_q == pee_pkg::ST_OK &&
						cq_data.kind == pee_pkg::TK_OP && cnt_q >= 2 &&
						!(cq_data.ch == pee_pkg::CH_SLASH && tos_q == '0)) begin
						state_d = pee_pkg::BK_EXEC;
					end else if (cq_data.last) begin
						state_d = pee_pkg::BK_FIN;
					end
				end
			end
			pee_pkg::BK_EXEC: begin
				if (cmd_q.ch == pee_pkg::CH_SLASH) begin
					state_d = pee_pkg::BK_DIV;
				end else if (cmd_q.last) begin
					state_d = pee_pkg::BK_FIN;
				end else begin
					state_d = pee_pkg::BK_IDLE;
				end
			end
			pee_pkg::BK_DIV: begin
				if (dc_q == pee_pkg::DC_W'(W - 1)) begin
					state_d = pee_pkg::BK_DIVEND;
				end
			end
			pee_pkg::BK_DIVEND: begin
				state_d = cmd_q.last ? pee_pkg::BK_FIN : pee_pkg::BK_IDLE;
			end
			pee_pkg::BK_FIN: begin
				if (out_free) begin
					state_d = pee_pkg::BK_IDLE;
				end
			end
			default: state_d = pee_pkg::BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		take    = (state_q == pee_pkg::BK_IDLE) && !flags.empty;
		live    = take && cq_data.has_tok && (status_q == pee_pkg::ST_OK);
		do_push = live && (cq_data.kind == pee_pkg::TK_DIGIT) && !is_full;
		op_ok   = live && (cq_data.kind == pee_pkg::TK_OP) && (state_d == pee_pkg::BK_EXEC);
		cq_rd   = take;
	end

	always_ff @(posedge clk) begin
		rdata_q <= stack_q[rd_idx];
		if (do_push && cnt_q != '0) begin
			stack_q[top_idx] <= tos_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= cq_data;
		end
		if (state_q == pee_pkg::BK_EXEC) begin
			rem_q <= '0;
			quo_q <= mag_l;
			dvs_q <= mag_r;
			neg_q <= rdata_q[W-1] ^ tos_q[W-1];
		end else if (state_q == pee_pkg::BK_DIV) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
			end else begin
				rem_q <= trial[W-1:0];
			end
			quo_q <= {quo_q[W-2:0], !diff[W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pee_pkg::BK_IDLE;
			cnt_q       <= '0;
			status_q    <= pee_pkg::ST_OK;
			tos_q       <= '0;
			dc_q        <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			state_q <= state_d;
			// a new result may replace the one popped in the same cycle
			if (state_q == pee_pkg::BK_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				pee_pkg::BK_IDLE: begin
					dc_q <= '0;
					if (live) begin
						priority if (cq_data.kind == pee_pkg::TK_BAD) begin
							status_q <= pee_pkg::ST_BAD_TOKEN;
						end else if (cq_data.kind == pee_pkg::TK_DIGIT) begin
							if (is_full) begin
								status_q <= pee_pkg::ST_FULL;
							end else begin
								tos_q <= digit;
								cnt_q <= cnt_q + 1'b1;
							end
						end else if (cnt_q < 2) begin
							status_q <= pee_pkg::ST_UNDERFLOW;
						end else if (!op_ok) begin
							status_q <= pee_pkg::ST_DIV_ZERO;
						end
					end
				end
				pee_pkg::BK_EXEC: begin
					if (cmd_q.ch != pee_pkg::CH_SLASH) begin
						tos_q <= alu_res;
						cnt_q <= cnt_m1;
					end
				end
				pee_pkg::BK_DIV: begin
					dc_q <= dc_q + 1'b1;
				end
				pee_pkg::BK_DIVEND: begin
					tos_q <= neg_q ? (W'(0) - quo_q) : quo_q;
					cnt_q <= cnt_m1;
				end
				pee_pkg::BK_FIN: begin
					if (out_free) begin
						if (status_q == pee_pkg::ST_OK && cnt_q == pee_pkg::CNT_W'(1)) begin
							out_q.value  <= pee_pkg::OUT_W'(signed'(tos_q));
							out_q.status <= pee_pkg::ST_OK;
						end else begin
							out_q.value  <= '0;
							out_q.status <= (status_q == pee_pkg::ST_OK) ?
								pee_pkg::ST_DEPTH : status_q;
						end
						cnt_q    <= '0;
						status_q <= pee_pkg::ST_OK;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule

// ===== hdl/postfix_expression_evaluator.sv =====
// top level of the postfix expression evaluator: tokenizer, command queue, stack engine
// depends on pee_pkg, pee_front, pee_cmd_fifo, pee_back
//
// bytes of an expression are pushed in one per cycle while full is low; full rises
// only when the four-entry command queue fills. every separator or the marked last
// byte turns a pending token into a command; a token of more than one character is
// classified as bad. the stack engine takes each command in its idle state: a digit
// or a rejected token ends there, + - * go on to an execute state, and / goes on
// through an execute state that loads the divider, a divide state that yields one
// quotient bit per cycle, and a write-back state. a finish state posts the result
// once the output register is free. the stack is a 32 x 32 memory below a top-of-stack
// register, read one entry a cycle; it needs no clearing pass since an entry is only
// read after it was written. one result (value and status) per expression waits in
// an output register until popped; the first error sticks until the end of the
// expression, and after each result the engine is ready for a new expression.
module postfix_expression_evaluator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  pee_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output pee_pkg::out_item_t result
);

	// queue between the halves
	pee_pkg::cq_flags_t flags;
	pee_pkg::cmd_t      wr_cmd;
	pee_pkg::cmd_t      rd_cmd;
	logic               cq_wr;
	logic               cq_rd;

	// front half: tokenizing and classification
	pee_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.flags   (flags),
		.cq_wr   (cq_wr),
		.cq_data (wr_cmd)
	);

	pee_cmd_fifo u_cq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cq_wr),
		.wdata  (wr_cmd),
		.rd     (cq_rd),
		.rdata  (rd_cmd),
		.flags  (flags)
	);

	// back half: stack, arithmetic and result
	pee_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.flags   (flags),
		.cq_data (rd_cmd),
		.cq_rd   (cq_rd),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// ===== hdl/pee_checker.sv =====
// port-level checks of the postfix expression evaluator, bound to the top level
// depends on pee_pkg and postfix_expression_evaluator_assert.svh
`include "postfix_expression_evaluator_assert.svh"

module pee_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input pee_pkg::out_item_t result
);

	`PEE_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(result))
	`PEE_ASSERT_NOW(a_status_range, !empty, result.status <= pee_pkg::ST_FULL)
	`PEE_ASSERT_NOW(a_err_zero, !empty && result.status != pee_pkg::ST_OK, result.value == '0)

endmodule

bind postfix_expression_evaluator pee_checker u_chk (.*);

// ===== bench/tb.sv =====
// testbench for the postfix expression evaluator: random and directed expressions,
// predicted in a scoreboard queue and checked against popped results
// depends on pee_pkg and postfix_expression_evaluator
module tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	pee_pkg::in_item_t item = '0;
	logic full, empty;
	pee_pkg::out_item_t result;

	postfix_expression_evaluator uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result)
	);

	always #5 clk = ~clk;

	// predictor state, a private copy of the evaluator
	logic [31:0] calc_stack [0:pee_pkg::STACK_DEPTH-1];
	int unsigned calc_depth;
	logic [7:0] tok_char;
	logic tok_open;
	logic tok_long;
	pee_pkg::status_t calc_status;

	pee_pkg::in_item_t pending_bytes [$];
	pee_pkg::out_item_t expected_results [$];
	int mismatches = 0;
	int checked = 0;
	int exprs = 0;
	int status_seen [0:7];
	logic feeding_done = 1'b0;
	logic hold_long = 1'b0;

	function automatic logic blank(input logic [7:0] c);
		return c == pee_pkg::CH_SPACE || (c >= pee_pkg::CH_TAB && c <= pee_pkg::CH_CR);
	endfunction

	task automatic calc_push(input logic [31:0] v);
		if (calc_depth >= pee_pkg::STACK_DEPTH) begin
			calc_status = pee_pkg::ST_FULL;
		end else begin
			calc_stack[calc_depth] = v;
			calc_depth++;
		end
	endtask

	task automatic calc_operator(input logic [7:0] op);
		logic [31:0] r, l, res, ml, mr;
		if (calc_depth < 2) begin
			calc_status = pee_pkg::ST_UNDERFLOW;
			return;
		end
		r = calc_stack[calc_depth-1];
		l = calc_stack[calc_depth-2];
		if (op == pee_pkg::CH_SLASH) begin
			if (r == 0) begin
				calc_status = pee_pkg::ST_DIV_ZERO;
				return;
			end
			ml = l[31] ? -l : l;
			mr = r[31] ? -r : r;
			res = ml / mr;
			if (l[31] != r[31])
				res = -res;
		end else if (op == pee_pkg::CH_PLUS) begin
			res = l + r;
		end else if (op == pee_pkg::CH_MINUS) begin
			res = l - r;
		end else begin
			res = l * r;
		end
		calc_depth -= 2;
		calc_push(res);
	endtask

	task automatic close_token();
		logic [7:0] c;
		logic had, lng;
		c = tok_char;
		had = tok_open;
		lng = tok_long;
		tok_open = 1'b0;
		tok_char = '0;
		tok_long = 1'b0;
		if (!had || calc_status != pee_pkg::ST_OK)
			return;
		if (lng)
			calc_status = pee_pkg::ST_BAD_TOKEN;
		else if (c >= pee_pkg::CH_ZERO && c <= pee_pkg::CH_NINE)
			calc_push(32'(c - pee_pkg::CH_ZERO));
		else if (c == pee_pkg::CH_PLUS || c == pee_pkg::CH_MINUS ||
			c == pee_pkg::CH_STAR || c == pee_pkg::CH_SLASH)
			calc_operator(c);
		else
			calc_status = pee_pkg::ST_BAD_TOKEN;
	endtask

	task automatic calc_clear();
		calc_depth = 0;
		tok_char = '0;
		tok_open = 1'b0;
		tok_long = 1'b0;
		calc_status = pee_pkg::ST_OK;
	endtask

	// expected result, if any, for one accepted byte
	task automatic predict_byte(input pee_pkg::in_item_t it);
		pee_pkg::out_item_t e;
		if (calc_status == pee_pkg::ST_OK) begin
			if (blank(it.byte_in))
				close_token();
			else if (tok_open)
				tok_long = 1'b1;
			else begin
				tok_char = it.byte_in;
				tok_open = 1'b1;
			end
		end
		if (!it.last_byte)
			return;
		close_token();
		if (calc_status == pee_pkg::ST_OK && calc_depth != 1)
			calc_status = pee_pkg::ST_DEPTH;
		e.status = calc_status;
		e.value = (calc_status == pee_pkg::ST_OK) ? calc_stack[0] : '0;
		expected_results.push_back(e);
		calc_clear();
	endtask

	// stimulus helpers
	task automatic add_byte(input logic [7:0] c, input logic l);
		pee_pkg::in_item_t it;
		it.byte_in = c;
		it.last_byte = l;
		pending_bytes.push_back(it);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] pick_sep();
		case ($urandom_range(0, 7))
			0: return pee_pkg::CH_TAB;
			1: return 8'($urandom_range(10, 13));
			default: return pee_pkg::CH_SPACE;
		endcase
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(0, 3))
			0: return pee_pkg::CH_PLUS;
			1: return pee_pkg::CH_MINUS;
			2: return pee_pkg::CH_STAR;
			default: return pee_pkg::CH_SLASH;
		endcase
	endfunction

	// random expression: depth capped at maxd, random ops, one trailing separator optional
	task automatic add_good_expr(input int ntok, input int maxd);
		int d;
		logic [7:0] t;
		d = 0;
		for (int k = 0; k < ntok || d != 1; k++) begin
			if (d >= 2 && (d >= maxd || $urandom_range(0, 1) || k >= ntok))
				t = pick_op();
			else
				t = pee_pkg::CH_ZERO + 8'($urandom_range(0, 9));
			d = (t >= pee_pkg::CH_ZERO) ? d + 1 : d - 1;
			if (k > 0)
				add_byte(pick_sep(), 1'b0);
			add_byte(t, 1'b0);
			if (k > 4 * ntok + 70)
				break;
		end
		if ($urandom_range(0, 1))
			add_byte(pick_sep(), 1'b1);
		else begin
			t = pending_bytes[$].byte_in;
			void'(pending_bytes.pop_back());
			add_byte(t, 1'b1);
		end
	endtask

	// random noise bytes, any code
	task automatic add_noise_expr(input int n);
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: c = 8'($urandom_range(0, 255));
				1: c = pick_sep();
				2: c = pick_op();
				default: c = pee_pkg::CH_ZERO + 8'($urandom_range(0, 9));
			endcase
			add_byte(c, i == n - 1);
		end
	endtask

	initial begin
		string s;
		calc_clear();
		for (int i = 0; i < 8; i++)
			status_seen[i] = 0;
		// directed: each operator, wrap cases, each error, blank, high codes
		add_text("3 4 +");
		add_text("3 4 - 5 *");
		add_text("7 0 2 - /");
		add_text("9 9 * 9 * 9 * 9 * 9 * 9 * 9 * 9 * 9 * 9 * 0 1 - /");
		add_text("12 +");
		add_text("5 +");
		add_text("5 0 /");
		add_text("1 2");
		add_byte(pee_pkg::CH_SPACE, 1'b1);
		add_byte(8'hff, 1'b1);
		add_byte(8'h80, 1'b1);
		add_byte(8'h00, 1'b1);
		add_text("\t8\n\r");
		// most negative / -1: 2^31 from 2*2*... then divide
		s = "0 1 - 2";
		for (int i = 0; i < 30; i++)
			s = {s, " 2 *"};
		s = {s, " * 0 1 - /"};
		add_text(s);
		// fill stack past its depth
		s = "";
		for (int i = 0; i < pee_pkg::STACK_DEPTH + 1; i++)
			s = {s, "1 "};
		add_text(s);
		// random part
		while (pending_bytes.size() < 1950) begin
			case ($urandom_range(0, 9))
				0: add_noise_expr($urandom_range(1, 12));
				1: add_good_expr($urandom_range(30, 40), pee_pkg::STACK_DEPTH + 2);
				default: add_good_expr($urandom_range(1, 8), 6);
			endcase
		end
		feeding_done = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver: bursts of pushes with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				predict_byte(item);
				void'(pending_bytes.pop_front());
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				push <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				// the head byte is offered until accepted
				item <= pending_bytes[0];
				push <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// long receiver hold-off early in the run, so the block backs up
	initial begin
		hold_long = 1'b1;
		wait (arst_n);
		for (int i = 0; i < 3000; i++)
			@(posedge clk);
		hold_long = 1'b0;
	end

	// monitor: random stall pattern, checks each popped result
	int stall_phase = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result value=%0d status=%0d",
							result.value, result.status);
				end else begin
					pee_pkg::out_item_t e;
					e = expected_results.pop_front();
					checked++;
					status_seen[e.status]++;
					if (e.value !== result.value || e.status !== result.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
								e.value, e.status, result.value, result.status);
					end
				end
			end
			stall_phase <= (stall_phase + 1) % 23;
			pop <= !hold_long && (stall_phase < 12 || $urandom_range(0, 3) == 0);
		end
	end

	// end of run once all bytes are in and every result came back
	initial begin
		wait (arst_n);
		wait (feeding_done && pending_bytes.size() == 0 && !push);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("checked %0d expressions: ok %0d, bad token %0d, underflow %0d, div0 %0d",
			checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		$display("depth errors %0d, stack full %0d, mismatches %0d",
			status_seen[4], status_seen[5], mismatches);
		if (mismatches == 0 && empty)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#6000000;
		$display("simulation failed");
		$finish;
	end
endmodule

// ===== postfix_expression_evaluator.f =====
+incdir+hdl
hdl/pee_pkg.sv
hdl/pee_cmd_fifo.sv
hdl/pee_front.sv
hdl/pee_back.sv
hdl/postfix_expression_evaluator.sv
hdl/pee_checker.sv
bench/tb.sv
